// ===== rtl/bpv_pkg.sv =====
// ----------------------------------------------------------------------------
// bpv_pkg
// Shared constants and the result record of the block pattern validator.
// ----------------------------------------------------------------------------
package bpv_pkg;

    // Block length limits that select the kind of check.
    localparam logic [31:0] LONG_BLOCK_MIN  = 32'd16;
    localparam logic [31:0] SHORT_BLOCK_MIN = 32'd2;

    // Rotation applied to the running sum before each payload byte is added.
    localparam int unsigned ROT_AMOUNT = 3;

    // Bytes of header (stored checksum then stored length) in a long block.
    localparam logic [31:0] HEADER_BYTES = 32'd8;

    // Length and checksum words of the header.
    localparam int unsigned WORD_BYTES = 4;

    // Length register value after reset.
    localparam logic [31:0] RESET_BLOCK_LENGTH = 32'd16;

    // Result fields, packed with block_ok in the lowest bit.
    typedef struct packed {
        logic [31:0] computed_sum;
        logic        length_matches;
        logic        block_ok;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);
    localparam int unsigned OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/block_pattern_validator_unit.sv =====
// ----------------------------------------------------------------------------
// block_pattern_validator_unit
// Checks blocks of a validation pattern arriving one byte per item and gives
// one pass/fail verdict per block.
// ----------------------------------------------------------------------------
// One byte is taken in every clock cycle. The block length comes from the
// configuration register; each byte updates the block state (header capture,
// rotate-left-by-3 add, or uniformity check), and the last byte of a block
// loads the verdict into an output register. Bytes that do not end a block
// are accepted even while a verdict waits to be taken; only a byte that ends
// a block waits for the output register to be free, so the input stalls only
// when a verdict is still unread at the end of the next block. Blocks of 16
// or more bytes carry a little-endian checksum (bytes 0 to 3) and length
// (bytes 4 to 7); blocks of 2 to 15 bytes pass when all bytes are equal; a
// length below 2 makes every byte a failing block. Writing the length
// register abandons any partial block.
// ----------------------------------------------------------------------------
module block_pattern_validator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: block length in bytes.
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    // Input stream. tdata: [7:0] data_byte.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,
    // Result stream. tdata: [0] block_ok, [1] length_matches,
    // [33:2] computed_sum, [39:34] zero.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [bpv_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);

    import bpv_pkg::*;

    // Configuration and decoded length.
    logic [31:0] r_block_length;
    logic [31:0] r_last_pos;
    logic        r_len_lt2;
    logic        r_len_lt16;

    // Block state.
    logic [31:0] r_pos;
    logic [31:0] r_sum;
    logic [31:0] r_stored_sum;
    logic [31:0] r_stored_len;
    logic [7:0]  r_first;
    logic        r_all_eq;

    // Output register.
    logic        r_out_valid;
    t_result     r_out;

    logic        w_emit;
    logic        w_accept;
    logic [7:0]  w_byte;
    logic        w_pos0;
    logic [1:0]  w_lane;
    logic [31:0] w_lane_word;
    logic [31:0] n_sum;
    logic [31:0] n_stored_sum;
    logic [31:0] n_stored_len;
    logic [7:0]  n_first;
    logic        n_all_eq;
    t_result     n_out;

    assign w_byte = i_s_axis_tdata[7:0];
    assign w_pos0 = (r_pos == 32'd0);
    assign w_lane = r_pos[1:0];

    // A byte ends a block when the length is below two or it is the last one.
    assign w_emit   = r_len_lt2 || (r_pos == r_last_pos);
    assign o_s_axis_tready = !w_emit || !r_out_valid || i_m_axis_tready;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // Byte placed at its little-endian lane within a header word.
    assign w_lane_word = {24'd0, w_byte} << {w_lane, 3'b000};

    // Next block state for the accepted byte.
    always_comb begin
        n_sum        = w_pos0 ? r_block_length : r_sum;
        n_stored_sum = w_pos0 ? 32'd0 : r_stored_sum;
        n_stored_len = w_pos0 ? 32'd0 : r_stored_len;
        if (r_pos < 32'(WORD_BYTES)) begin
            n_stored_sum = n_stored_sum | w_lane_word;
        end else if (r_pos < HEADER_BYTES) begin
            n_stored_len = n_stored_len | w_lane_word;
        end else begin
            n_sum = {n_sum[31-ROT_AMOUNT:0], n_sum[31:32-ROT_AMOUNT]} + {24'd0, w_byte};
        end

        // Uniformity check for short blocks.
        if (w_pos0) begin
            n_first  = w_byte;
            n_all_eq = 1'b1;
        end else begin
            n_first  = r_first;
            n_all_eq = r_all_eq && (w_byte == r_first);
        end

        // Verdict for a block ending on this byte.
        n_out = '0;
        if (r_len_lt2) begin
            n_out = '0;
        end else if (r_len_lt16) begin
            n_out.block_ok = n_all_eq;
        end else begin
            n_out.length_matches = (n_stored_len == r_block_length);
            n_out.block_ok       = n_out.length_matches && (n_stored_sum == n_sum);
            n_out.computed_sum   = n_sum;
        end
    end

    // Configuration register and its decodes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length <= RESET_BLOCK_LENGTH;
            r_last_pos     <= RESET_BLOCK_LENGTH - 32'd1;
            r_len_lt2      <= (RESET_BLOCK_LENGTH < SHORT_BLOCK_MIN);
            r_len_lt16     <= (RESET_BLOCK_LENGTH < LONG_BLOCK_MIN);
        end else if (i_cfg_wr_en) begin
            r_block_length <= i_cfg_wr_data;
            r_last_pos     <= i_cfg_wr_data - 32'd1;
            r_len_lt2      <= (i_cfg_wr_data < SHORT_BLOCK_MIN);
            r_len_lt16     <= (i_cfg_wr_data < LONG_BLOCK_MIN);
        end
    end

    // Block state: restart on reset, on a length write and at block end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_sum        <= RESET_BLOCK_LENGTH;
            r_stored_sum <= '0;
            r_stored_len <= '0;
            r_first      <= '0;
            r_all_eq     <= 1'b1;
        end else if (i_cfg_wr_en) begin
            r_pos        <= '0;
            r_sum        <= i_cfg_wr_data;
            r_stored_sum <= '0;
            r_stored_len <= '0;
            r_first      <= '0;
            r_all_eq     <= 1'b1;
        end else if (w_accept) begin
            if (w_emit) begin
                r_pos        <= '0;
                r_sum        <= r_block_length;
                r_stored_sum <= '0;
                r_stored_len <= '0;
                r_first      <= '0;
                r_all_eq     <= 1'b1;
            end else begin
                r_pos        <= r_pos + 32'd1;
                r_all_eq     <= n_all_eq;
                r_first      <= n_first;
                if (!r_len_lt16) begin
                    r_sum        <= n_sum;
                    r_stored_sum <= n_stored_sum;
                    r_stored_len <= n_stored_len;
                end
            end
        end
    end

    // Output register: loaded on a block end, cleared when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out <= n_out;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - RESULT_W){1'b0}}, r_out};

    // A length below two turns every byte into a failing, all-zero verdict.
    a_tiny_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_len_lt2 && !i_cfg_wr_en) |=>
        (o_m_axis_tvalid && o_m_axis_tdata == '0))
        else $error("tiny block verdict not all zero");

    // The byte position never runs past the last byte of a block.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_len_lt2 |-> (r_pos <= r_last_pos))
        else $error("byte position beyond block end");

    // Short-block verdicts carry no length match and no sum.
    a_short_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_len_lt16) |-> (o_m_axis_tdata[OUT_TDATA_W-1:1] == '0))
        else $error("short block verdict has non-zero fields");

    // A block end restarts the byte position.
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_emit) |=> (r_pos == 32'd0))
        else $error("block end did not restart position");

    // A pass on a long block implies a length match.
    a_pass_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !r_len_lt16 && o_m_axis_tdata[0]) |-> o_m_axis_tdata[1])
        else $error("long block passed without length match");

endmodule
